@@ hw/rtl/ffa_pkg.sv @@
// shared types, constants and codes for the first-fit block allocator
`default_nettype none

package ffa_pkg;

    localparam int unsigned MAX_BLOCKS_DEF  = 16;
    localparam int unsigned OFFSET_BITS_DEF = 21;

    localparam int unsigned HANDLE_BITS   = 4;
    localparam int unsigned SIZE_BITS     = 21;
    localparam int unsigned LEN_BITS      = 21;
    localparam int unsigned ADDR_BITS     = 33;
    localparam int unsigned BASE_BITS     = 32;
    localparam int unsigned CFG_IDX_BITS  = 8;
    localparam int unsigned CFG_DATA_BITS = 32;

    localparam logic [BASE_BITS-1:0] POOL_BASE_RESET = '0;
    localparam logic [SIZE_BITS-1:0] POOL_SIZE_RESET = 21'h100000;

    localparam logic [CFG_IDX_BITS-1:0] REG_POOL_BASE = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POOL_SIZE = 8'd1;

    typedef enum logic [1:0] {
        MODE_ALLOC,
        MODE_RESIZE,
        MODE_FREE,
        MODE_COMPACT
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_MEM,
        ST_BAD_FREE,
        ST_NO_SLOT
    } status_t;

    typedef struct packed {
        mode_t                  mode;
        logic [HANDLE_BITS-1:0] handle;
        logic                   handle_null;
        logic [SIZE_BITS-1:0]   request_size;
    } request_t;

    typedef struct packed {
        status_t                status;
        logic [HANDLE_BITS-1:0] result_handle;
        logic [ADDR_BITS-1:0]   block_address;
        logic [ADDR_BITS-1:0]   source_address;
        logic                   move_needed;
        logic [LEN_BITS-1:0]    move_length;
        logic                   last;
    } result_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_SCAN,
        CMD_COMPACT,
        CMD_ALLOC,
        CMD_INPLACE,
        CMD_REMOVE,
        CMD_MOVE,
        CMD_FREE,
        CMD_ERR_SLOT,
        CMD_ERR_MEM,
        CMD_ERR_FREE,
        CMD_EMPTY
    } ffa_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  alloc_like;
        logic  handle_ok;
        logic  slot_free;
        logic  empty;
        logic  walk_done;
        logic  fit_ok;
        logic  keep_place;
    } ffa_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ffa_ctrl.sv @@
// request sequencer of the first-fit block allocator
`default_nettype none

module ffa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire ffa_pkg::ffa_stat_t stat,
    output ffa_pkg::ffa_cmd_t     cmd,
    output logic                  busy
);
    import ffa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_COMPACT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.alloc_like)
                begin
                    if (stat.slot_free)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd        = CMD_ERR_SLOT;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    case (stat.mode)
                        MODE_RESIZE:
                        begin
                            if (stat.handle_ok)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                cmd        = CMD_ERR_FREE;
                                state_next = S_IDLE;
                            end
                        end
                        MODE_FREE:
                        begin
                            cmd        = stat.handle_ok ? CMD_FREE : CMD_ERR_FREE;
                            state_next = S_IDLE;
                        end
                        MODE_COMPACT:
                        begin
                            if (stat.empty)
                            begin
                                cmd        = CMD_EMPTY;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_COMPACT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd = CMD_SCAN;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                if (stat.alloc_like)
                begin
                    cmd = stat.fit_ok ? CMD_ALLOC : CMD_ERR_MEM;
                end
                else if (stat.keep_place)
                begin
                    cmd = CMD_INPLACE;
                end
                else if (stat.fit_ok)
                begin
                    cmd        = CMD_REMOVE;
                    state_next = S_MOVE;
                end
                else
                begin
                    cmd = CMD_ERR_MEM;
                end
            end
            S_MOVE:
            begin
                cmd        = CMD_MOVE;
                state_next = S_IDLE;
            end
            S_COMPACT:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd = CMD_COMPACT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ffa_datapath.sv @@
// block table, order list, table walk and result register of the allocator
`default_nettype none

module ffa_datapath #(
    parameter int unsigned MAX_BLOCKS  = ffa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned OFFSET_BITS = ffa_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ffa_pkg::ffa_cmd_t                   cmd,
    input  wire ffa_pkg::request_t                   req,
    input  wire logic                                cfg_valid,
    input  wire logic [ffa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [ffa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output ffa_pkg::ffa_stat_t                       stat,
    output logic                                     result_valid,
    output ffa_pkg::result_t                         result
);
    import ffa_pkg::*;

    localparam int unsigned SW = $clog2(MAX_BLOCKS);
    localparam int unsigned PW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned OB = OFFSET_BITS;
    localparam int unsigned WW = (OB > SIZE_BITS) ? OB : SIZE_BITS;

    function automatic logic room_ge(input logic [WW-1:0] from, input logic [WW-1:0] upto,
                                     input logic [WW-1:0] need);
        logic [WW-1:0] d;
        begin
            d = upto - from;
            return (upto >= from) ? (d >= need) : (need == '0);
        end
    endfunction

    function automatic logic [ADDR_BITS-1:0] to_addr(input logic [BASE_BITS-1:0] base,
                                                     input logic [OB-1:0] off);
        return ADDR_BITS'(base) + ADDR_BITS'(off);
    endfunction

    // block table: {length, offset} per slot
    logic [2*OB-1:0] blk_mem [MAX_BLOCKS];
    logic [2*OB-1:0] mem_q_reg;
    logic            mem_we;
    logic [SW-1:0]   mem_wa;
    logic [2*OB-1:0] mem_wd;
    logic [SW-1:0]   mem_ra;

    logic [BASE_BITS-1:0]  pool_base_reg;
    logic [SIZE_BITS-1:0]  pool_size_reg;

    request_t              req_reg, req_next;
    logic [PW-1:0]         count_reg, count_next;
    logic [MAX_BLOCKS-1:0] in_use_reg, in_use_next;
    logic [SW-1:0]         ord_reg [MAX_BLOCKS];
    logic [SW-1:0]         ord_next [MAX_BLOCKS];

    logic [PW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [PW-1:0] ev_idx_reg, ev_idx_next;
    logic [SW-1:0] ev_slot_reg, ev_slot_next;
    logic          found_reg, found_next;
    logic [PW-1:0] fpos_reg, fpos_next;
    logic [OB-1:0] foff_reg, foff_next;
    logic [OB-1:0] prev_end_reg, prev_end_next;
    logic          prev_me_reg, prev_me_next;
    logic          has_next_reg, has_next_next;
    logic [OB-1:0] next_off_reg, next_off_next;
    logic [OB-1:0] old_off_reg, old_off_next;
    logic [OB-1:0] old_len_reg, old_len_next;
    logic [PW-1:0] me_reg, me_next;
    logic [OB-1:0] dst_reg, dst_next;

    logic    res_valid_reg, res_valid_next;
    result_t res_reg, res_next;

    logic [SW-1:0] hs;
    logic [SW-1:0] free_slot;
    logic          slot_free;
    logic [PW-1:0] me_pos;
    logic          handle_ok;
    logic [OB-1:0] q_off, q_len, q_end;
    logic [WW-1:0] size_w, pool_w;
    logic          end_fit, tail_ok, inplace_ok;
    logic [OB-1:0] fit_off;
    logic [PW-1:0] fit_pos;
    logic [PW-1:0] last_idx;

    logic          do_rm, do_ins;
    logic [PW-1:0] rm_pos, ins_pos;
    logic [SW-1:0] ins_slot;
    logic          moved;

    assign hs        = SW'(req_reg.handle);
    assign q_off     = mem_q_reg[OB-1:0];
    assign q_len     = mem_q_reg[2*OB-1:OB];
    assign q_end     = q_off + q_len;
    assign size_w    = WW'(req_reg.request_size);
    assign pool_w    = WW'(pool_size_reg);
    assign last_idx  = count_reg - PW'(1);
    assign slot_free = ~&in_use_reg;
    assign handle_ok = !req_reg.handle_null && (32'(req_reg.handle) < MAX_BLOCKS) &&
                       in_use_reg[hs];
    assign mem_ra    = ord_reg[rd_idx_reg[SW-1:0]];

    always_comb
    begin
        free_slot = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    always_comb
    begin
        me_pos = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            if ((ord_reg[i] == hs) && (PW'(i) < count_reg))
            begin
                me_pos = PW'(i);
            end
        end
    end

    assign end_fit    = room_ge(WW'(prev_end_reg), pool_w, size_w);
    assign tail_ok    = (me_reg == last_idx) && room_ge(WW'(old_off_reg), pool_w, size_w);
    assign inplace_ok = (size_w <= WW'(old_len_reg)) ||
                        (has_next_reg && room_ge(WW'(old_off_reg), WW'(next_off_reg), size_w));
    assign fit_off    = found_reg ? foff_reg : prev_end_reg;
    assign fit_pos    = found_reg ? fpos_reg : count_reg;

    always_comb
    begin
        stat.mode       = req_reg.mode;
        stat.alloc_like = (req_reg.mode == MODE_ALLOC) ||
                          ((req_reg.mode == MODE_RESIZE) && req_reg.handle_null);
        stat.handle_ok  = handle_ok;
        stat.slot_free  = slot_free;
        stat.empty      = (count_reg == '0);
        stat.walk_done  = (rd_idx_reg == count_reg) && !pend_reg;
        stat.fit_ok     = found_reg || end_fit;
        stat.keep_place = inplace_ok || (!found_reg && tail_ok);
    end

    always_comb
    begin
        req_next       = req_reg;
        count_next     = count_reg;
        in_use_next    = in_use_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        ev_idx_next    = ev_idx_reg;
        ev_slot_next   = ev_slot_reg;
        found_next     = found_reg;
        fpos_next      = fpos_reg;
        foff_next      = foff_reg;
        prev_end_next  = prev_end_reg;
        prev_me_next   = prev_me_reg;
        has_next_next  = has_next_reg;
        next_off_next  = next_off_reg;
        old_off_next   = old_off_reg;
        old_len_next   = old_len_reg;
        me_next        = me_reg;
        dst_next       = dst_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_wa         = hs;
        mem_wd         = '0;
        do_rm          = 1'b0;
        do_ins         = 1'b0;
        rm_pos         = me_pos;
        ins_pos        = fit_pos;
        ins_slot       = hs;
        moved          = 1'b0;

        case (cmd)
            CMD_LATCH:
            begin
                req_next      = req;
                rd_idx_next   = '0;
                pend_next     = 1'b0;
                found_next    = 1'b0;
                fpos_next     = '0;
                prev_end_next = '0;
                prev_me_next  = 1'b0;
                has_next_next = 1'b0;
                dst_next      = '0;
            end
            CMD_SCAN, CMD_COMPACT:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    pend_next    = 1'b1;
                    ev_idx_next  = rd_idx_reg;
                    ev_slot_next = mem_ra;
                    rd_idx_next  = rd_idx_reg + PW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && (cmd == CMD_SCAN))
                begin
                    if (!found_reg)
                    begin
                        if (ev_idx_reg == '0)
                        begin
                            if (WW'(q_off) >= size_w)
                            begin
                                found_next = 1'b1;
                                fpos_next  = '0;
                                foff_next  = '0;
                            end
                        end
                        else if (room_ge(WW'(prev_end_reg), WW'(q_off), size_w))
                        begin
                            found_next = 1'b1;
                            fpos_next  = ev_idx_reg;
                            foff_next  = prev_end_reg;
                        end
                    end
                    prev_end_next = q_end;
                    if (prev_me_reg)
                    begin
                        has_next_next = 1'b1;
                        next_off_next = q_off;
                    end
                    prev_me_next = (ev_slot_reg == hs);
                    if (ev_slot_reg == hs)
                    begin
                        old_off_next = q_off;
                        old_len_next = q_len;
                        me_next      = ev_idx_reg;
                    end
                end
                else if (pend_reg)
                begin
                    moved                   = (q_off != dst_reg);
                    res_valid_next          = 1'b1;
                    res_next                = '0;
                    res_next.status         = ST_OK;
                    res_next.result_handle  = HANDLE_BITS'(ev_slot_reg);
                    res_next.block_address  = to_addr(pool_base_reg, dst_reg);
                    res_next.source_address = moved ? to_addr(pool_base_reg, q_off) : '0;
                    res_next.move_needed    = moved;
                    res_next.move_length    = moved ? LEN_BITS'(q_len) : '0;
                    res_next.last           = (ev_idx_reg == last_idx);
                    mem_we                  = 1'b1;
                    mem_wa                  = ev_slot_reg;
                    mem_wd                  = {q_len, dst_reg};
                    dst_next                = dst_reg + q_len;
                end
            end
            CMD_ALLOC:
            begin
                mem_we                 = 1'b1;
                mem_wa                 = free_slot;
                mem_wd                 = {OB'(req_reg.request_size), fit_off};
                in_use_next[free_slot] = 1'b1;
                do_ins                 = 1'b1;
                ins_pos                = fit_pos;
                ins_slot               = free_slot;
                count_next             = count_reg + PW'(1);
                res_valid_next         = 1'b1;
                res_next               = '0;
                res_next.status        = ST_OK;
                res_next.result_handle = HANDLE_BITS'(free_slot);
                res_next.block_address = to_addr(pool_base_reg, fit_off);
                res_next.last          = 1'b1;
            end
            CMD_INPLACE:
            begin
                mem_we                 = 1'b1;
                mem_wa                 = hs;
                mem_wd                 = {OB'(req_reg.request_size), old_off_reg};
                res_valid_next         = 1'b1;
                res_next               = '0;
                res_next.status        = ST_OK;
                res_next.result_handle = req_reg.handle;
                res_next.block_address = to_addr(pool_base_reg, old_off_reg);
                res_next.last          = 1'b1;
            end
            CMD_REMOVE:
            begin
                do_rm      = 1'b1;
                rm_pos     = me_reg;
                count_next = count_reg - PW'(1);
                fpos_next  = (fit_pos > me_reg) ? (fit_pos - PW'(1)) : fit_pos;
                foff_next  = fit_off;
                found_next = 1'b1;
            end
            CMD_MOVE:
            begin
                do_ins                  = 1'b1;
                ins_pos                 = fpos_reg;
                ins_slot                = hs;
                count_next              = count_reg + PW'(1);
                mem_we                  = 1'b1;
                mem_wa                  = hs;
                mem_wd                  = {OB'(req_reg.request_size), foff_reg};
                res_valid_next          = 1'b1;
                res_next                = '0;
                res_next.status         = ST_OK;
                res_next.result_handle  = req_reg.handle;
                res_next.block_address  = to_addr(pool_base_reg, foff_reg);
                res_next.source_address = to_addr(pool_base_reg, old_off_reg);
                res_next.move_needed    = 1'b1;
                res_next.move_length    = LEN_BITS'(old_len_reg);
                res_next.last           = 1'b1;
            end
            CMD_FREE:
            begin
                do_rm                  = 1'b1;
                rm_pos                 = me_pos;
                in_use_next[hs]        = 1'b0;
                count_next             = count_reg - PW'(1);
                res_valid_next         = 1'b1;
                res_next               = '0;
                res_next.status        = ST_OK;
                res_next.result_handle = req_reg.handle;
                res_next.last          = 1'b1;
            end
            CMD_ERR_SLOT, CMD_ERR_MEM, CMD_ERR_FREE, CMD_EMPTY:
            begin
                res_valid_next = 1'b1;
                res_next       = '0;
                res_next.last  = 1'b1;
                case (cmd)
                    CMD_ERR_SLOT: res_next.status = ST_NO_SLOT;
                    CMD_ERR_MEM:  res_next.status = ST_NO_MEM;
                    CMD_ERR_FREE: res_next.status = ST_BAD_FREE;
                    default:      res_next.status = ST_OK;
                endcase
            end
            default:
            begin
            end
        endcase

        // order list shifts
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            ord_next[i] = ord_reg[i];
        end
        if (do_rm)
        begin
            for (int i = 0; i < MAX_BLOCKS - 1; i++)
            begin
                if (PW'(i) >= rm_pos)
                begin
                    ord_next[i] = ord_reg[i + 1];
                end
            end
        end
        if (do_ins)
        begin
            for (int i = 1; i < MAX_BLOCKS; i++)
            begin
                if (PW'(i) > ins_pos)
                begin
                    ord_next[i] = ord_reg[i - 1];
                end
            end
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                if (PW'(i) == ins_pos)
                begin
                    ord_next[i] = ins_slot;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            blk_mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= blk_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= POOL_BASE_RESET;
            pool_size_reg <= POOL_SIZE_RESET;
            count_reg     <= '0;
            in_use_reg    <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_POOL_BASE: pool_base_reg <= cfg_data;
                    REG_POOL_SIZE: pool_size_reg <= cfg_data[SIZE_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            count_reg     <= count_next;
            in_use_reg    <= in_use_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ev_idx_reg   <= ev_idx_next;
        ev_slot_reg  <= ev_slot_next;
        found_reg    <= found_next;
        fpos_reg     <= fpos_next;
        foff_reg     <= foff_next;
        prev_end_reg <= prev_end_next;
        prev_me_reg  <= prev_me_next;
        has_next_reg <= has_next_next;
        next_off_reg <= next_off_next;
        old_off_reg  <= old_off_next;
        old_len_reg  <= old_len_next;
        me_reg       <= me_next;
        dst_reg      <= dst_next;
        res_reg      <= res_next;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            ord_reg[i] <= ord_next[i];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_block_allocator_core.sv @@
// top level of the first-fit block allocator with compaction
//
// channel   direction  handshake                       payload
// request   in         start && !busy                  request (mode, handle, size)
// result    out        result_valid, one cycle strobe  result (status, addresses, move)
// config    in         cfg_valid && cfg_ready          cfg_index, cfg_data
//
// allocate and resize walk the block table once
// compact emits one transaction per block on consecutive cycles
// free and handle or slot errors skip the table walk; the walk rate is set by one table read per cycle
// reset clears slot usage and the block count at once, no clearing pass
// busy stays high until the final transaction of a request is issued
// results cannot be held off, so the block never stalls on the output side
`default_nettype none

module first_fit_block_allocator_core #(
    parameter int unsigned MAX_BLOCKS  = ffa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned OFFSET_BITS = ffa_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire ffa_pkg::request_t                 request,
    output logic                                   busy,
    output logic                                   result_valid,
    output ffa_pkg::result_t                       result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ffa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [ffa_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import ffa_pkg::*;

    ffa_cmd_t  cmd;
    ffa_stat_t stat;

    assign cfg_ready = 1'b1;

    ffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ffa_datapath #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req          (request),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_compact_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> result_valid)
        else $error("gap inside a multi-transaction burst");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_OK)) |->
            (result.last && !result.move_needed && (result.block_address == '0)))
        else $error("error transaction not final or not cleared");

endmodule

`default_nettype wire
